>>> rtl/core/spiral_matrix_reader_core_defines.svh
// Assertion macros shared by the spiral matrix reader modules.
// Each macro expects signals named clock and reset in the using module.
`ifndef SPIRAL_MATRIX_READER_CORE_DEFINES_SVH
`define SPIRAL_MATRIX_READER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define SMR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`define SMR_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`else
`define SMR_ASSERT_NEXT(label, ante, cons, msg)
`define SMR_ASSERT_SAME(label, ante, cons, msg)
`endif

`endif

>>> rtl/core/smr_pkg.sv
`timescale 1ns / 1ps

package smr_pkg;

   localparam int CfgWidth    = 5;
   localparam int CsrAddrBits = 3;
   localparam int DataWidth   = 32;

   // Register indexes, taken from csr_paddr[2].
   localparam logic REG_ROW_COUNT    = 1'b0;
   localparam logic REG_COLUMN_COUNT = 1'b1;

   // Operation codes of an input beat.
   localparam logic OP_LOAD    = 1'b0;
   localparam logic OP_REQUEST = 1'b1;

   // Walk directions of the spiral.
   localparam logic [1:0] DIR_RIGHT = 2'd0;
   localparam logic [1:0] DIR_DOWN  = 2'd1;
   localparam logic [1:0] DIR_LEFT  = 2'd2;
   localparam logic [1:0] DIR_UP    = 2'd3;

   typedef enum logic [2:0] {
      ST_FILL = 3'b001,
      ST_WALK = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   typedef struct packed {
      logic load;        // write the element at the load pointer
      logic clear_load;  // rewind the load pointer to the first entry
      logic step;        // read the current spiral entry and advance
      logic respond;     // a result beat goes out next cycle
      logic empty;       // that result carries the empty flag
   } cmd_type;

   typedef struct packed {
      logic load_last;   // the load pointer sits on the final entry
      logic spiral_end;  // the current spiral entry is the final one
   } status_type;

endpackage

>>> rtl/core/smr_ctrl.sv
`timescale 1ns / 1ps
`include "spiral_matrix_reader_core_defines.svh"

module smr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                operation,
   input  logic                cfg_we,
   input  smr_pkg::status_type status,
   output smr_pkg::cmd_type    cmd
);

   smr_pkg::state_type state_ff;
   smr_pkg::state_type state_in;

   logic is_load;
   logic is_request;

   assign is_load    = start && (operation == smr_pkg::OP_LOAD);
   assign is_request = start && (operation == smr_pkg::OP_REQUEST);

   always_comb begin
      cmd            = '0;
      cmd.load       = is_load;
      cmd.clear_load = cfg_we;
      cmd.respond    = is_request;
      cmd.step       = is_request && (state_ff == smr_pkg::ST_WALK);
      cmd.empty      = is_request && (state_ff != smr_pkg::ST_WALK);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         smr_pkg::ST_FILL: begin
            if (is_load && status.load_last) begin
               state_in = smr_pkg::ST_WALK;
            end
         end
         smr_pkg::ST_WALK: begin
            if (is_load) begin
               state_in = status.load_last ? smr_pkg::ST_WALK : smr_pkg::ST_FILL;
            end else if (is_request && status.spiral_end) begin
               state_in = smr_pkg::ST_DONE;
            end
         end
         smr_pkg::ST_DONE: begin
            if (is_load) begin
               state_in = status.load_last ? smr_pkg::ST_WALK : smr_pkg::ST_FILL;
            end
         end
         default: begin
            state_in = smr_pkg::ST_FILL;
         end
      endcase
      if (cfg_we) begin
         state_in = smr_pkg::ST_FILL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= smr_pkg::ST_FILL;
      end else begin
         state_ff <= state_in;
      end
   end

   `SMR_ASSERT_NEXT(a_end_to_done, cmd.step && status.spiral_end && !cfg_we, state_ff == smr_pkg::ST_DONE, "final spiral beat did not finish the walk")
   `SMR_ASSERT_NEXT(a_full_to_walk, cmd.load && status.load_last && !cfg_we, state_ff == smr_pkg::ST_WALK, "full load did not open the walk")
   `SMR_ASSERT_NEXT(a_cfg_to_fill, cfg_we, state_ff == smr_pkg::ST_FILL, "register write did not restart loading")

endmodule

>>> rtl/core/smr_dpath.sv
`timescale 1ns / 1ps
`include "spiral_matrix_reader_core_defines.svh"

module smr_dpath #(
   parameter int MAX_ROWS    = 16,
   parameter int MAX_COLUMNS = 16,
   parameter int RowBits     = 4,
   parameter int ColBits     = 4,
   parameter int CountBits   = 9
) (
   input  logic                                clock,
   input  logic                                reset,
   input  smr_pkg::cmd_type                    cmd,
   input  logic [RowBits-1:0]                  rows_m1,
   input  logic [ColBits-1:0]                  cols_m1,
   input  logic signed [smr_pkg::DataWidth-1:0] element,
   output smr_pkg::status_type                 status,
   output logic                                rsp_valid,
   output logic signed [smr_pkg::DataWidth-1:0] rsp_value,
   output logic                                rsp_last,
   output logic                                rsp_empty_res
);

   localparam int MemDepth = MAX_ROWS * MAX_COLUMNS;
   localparam int AddrBits = (MemDepth > 1) ? $clog2(MemDepth) : 1;

   logic [smr_pkg::DataWidth-1:0] mem [MemDepth];
   logic [smr_pkg::DataWidth-1:0] rd_data_ff;

   logic [RowBits-1:0] ld_row_ff, ld_row_in;
   logic [ColBits-1:0] ld_col_ff, ld_col_in;

   logic [RowBits-1:0] top_ff, top_in, bot_ff, bot_in, cur_row_ff, cur_row_in;
   logic [ColBits-1:0] left_ff, left_in, right_ff, right_in, cur_col_ff, cur_col_in;
   logic [1:0]         dir_ff, dir_in;
   logic [CountBits-1:0] emit_ff, emit_in;

   logic rsp_valid_ff, rsp_last_ff, rsp_empty_ff;

   logic [AddrBits-1:0]  wr_addr, rd_addr;
   logic [CountBits-1:0] total_m1;

   assign wr_addr = AddrBits'(ld_row_ff) * AddrBits'(MAX_COLUMNS) + AddrBits'(ld_col_ff);
   assign rd_addr = AddrBits'(cur_row_ff) * AddrBits'(MAX_COLUMNS) + AddrBits'(cur_col_ff);

   assign total_m1 = CountBits'((CountBits'(rows_m1) + CountBits'(1))
                     * (CountBits'(cols_m1) + CountBits'(1)) - CountBits'(1));

   assign status.load_last  = (ld_row_ff == rows_m1) && (ld_col_ff == cols_m1);
   assign status.spiral_end = (emit_ff == total_m1);

   // Load pointer walks the matrix row-major and wraps after the final entry.
   always_comb begin
      ld_row_in = ld_row_ff;
      ld_col_in = ld_col_ff;
      if (cmd.clear_load) begin
         ld_row_in = '0;
         ld_col_in = '0;
      end else if (cmd.load) begin
         if (status.load_last) begin
            ld_row_in = '0;
            ld_col_in = '0;
         end else if (ld_col_ff == cols_m1) begin
            ld_row_in = ld_row_ff + RowBits'(1);
            ld_col_in = '0;
         end else begin
            ld_col_in = ld_col_ff + ColBits'(1);
         end
      end
   end

   // Every load restarts the walk; a step moves one entry clockwise and
   // shrinks the bound it leaves at a corner.
   always_comb begin
      top_in     = top_ff;
      bot_in     = bot_ff;
      left_in    = left_ff;
      right_in   = right_ff;
      dir_in     = dir_ff;
      cur_row_in = cur_row_ff;
      cur_col_in = cur_col_ff;
      emit_in    = emit_ff;
      if (cmd.load) begin
         top_in     = '0;
         bot_in     = rows_m1;
         left_in    = '0;
         right_in   = cols_m1;
         dir_in     = smr_pkg::DIR_RIGHT;
         cur_row_in = '0;
         cur_col_in = '0;
         emit_in    = '0;
      end else if (cmd.step) begin
         emit_in = emit_ff + CountBits'(1);
         case (dir_ff)
            smr_pkg::DIR_RIGHT: begin
               if (cur_col_ff < right_ff) begin
                  cur_col_in = cur_col_ff + ColBits'(1);
               end else begin
                  top_in     = top_ff + RowBits'(1);
                  dir_in     = smr_pkg::DIR_DOWN;
                  cur_row_in = top_ff + RowBits'(1);
                  cur_col_in = right_ff;
               end
            end
            smr_pkg::DIR_DOWN: begin
               if (cur_row_ff < bot_ff) begin
                  cur_row_in = cur_row_ff + RowBits'(1);
               end else begin
                  right_in   = right_ff - ColBits'(1);
                  dir_in     = smr_pkg::DIR_LEFT;
                  cur_col_in = right_ff - ColBits'(1);
                  cur_row_in = bot_ff;
               end
            end
            smr_pkg::DIR_LEFT: begin
               if (cur_col_ff > left_ff) begin
                  cur_col_in = cur_col_ff - ColBits'(1);
               end else begin
                  bot_in     = bot_ff - RowBits'(1);
                  dir_in     = smr_pkg::DIR_UP;
                  cur_row_in = bot_ff - RowBits'(1);
                  cur_col_in = left_ff;
               end
            end
            default: begin
               if (cur_row_ff > top_ff) begin
                  cur_row_in = cur_row_ff - RowBits'(1);
               end else begin
                  left_in    = left_ff + ColBits'(1);
                  dir_in     = smr_pkg::DIR_RIGHT;
                  cur_col_in = left_ff + ColBits'(1);
                  cur_row_in = top_ff;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mem[wr_addr] <= element;
      end
      if (cmd.step) begin
         rd_data_ff <= mem[rd_addr];
      end
      rsp_last_ff  <= cmd.step && status.spiral_end;
      rsp_empty_ff <= cmd.empty;
      top_ff       <= top_in;
      bot_ff       <= bot_in;
      left_ff      <= left_in;
      right_ff     <= right_in;
      dir_ff       <= dir_in;
      cur_row_ff   <= cur_row_in;
      cur_col_ff   <= cur_col_in;
      emit_ff      <= emit_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ld_row_ff    <= '0;
         ld_col_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ld_row_ff    <= ld_row_in;
         ld_col_ff    <= ld_col_in;
         rsp_valid_ff <= cmd.respond;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value     = rsp_empty_ff ? '0 : rd_data_ff;
   assign rsp_last      = rsp_last_ff;
   assign rsp_empty_res = rsp_empty_ff;

   `SMR_ASSERT_SAME(a_last_has_data, rsp_valid_ff && rsp_last_ff, !rsp_empty_ff, "last beat flagged empty")

endmodule

>>> rtl/core/spiral_matrix_reader_core.sv
`timescale 1ns / 1ps

// Spiral matrix reader.
// Input beats arrive on start with req_operation and req_element; busy is
// never raised, so a beat is taken on every cycle that start is high. A load
// beat writes the next entry in row-major order and produces no result. A
// request beat produces exactly one result beat on rsp_valid in the next cycle,
// carrying the next element of the clockwise spiral, with rsp_last on the
// final one. A request made before the matrix is fully loaded, or after the
// spiral has finished, returns zero with rsp_empty_res set.
// Throughput is one beat per cycle; each spiral element comes from the single
// registered read of the element memory. Each load restarts the
// spiral; loading into a full matrix begins a new one at the first entry.
// The csr port holds row_count (offset 0) and column_count (offset 4); a
// write restarts loading. Reset sets both counts to four and empties the
// matrix bookkeeping; the memory itself is not cleared. The result side has
// no back-pressure: every result beat is shown for a single cycle.
module spiral_matrix_reader_core #(
   parameter int MAX_ROWS    = 16,
   parameter int MAX_COLUMNS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic                                  req_operation,
   input  logic signed [smr_pkg::DataWidth-1:0]   req_element,
   output logic                                  rsp_valid,
   output logic signed [smr_pkg::DataWidth-1:0]   rsp_value,
   output logic                                  rsp_last,
   output logic                                  rsp_empty_res,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [smr_pkg::CsrAddrBits-1:0]       csr_paddr,
   input  logic [31:0]                           csr_pwdata,
   output logic [31:0]                           csr_prdata,
   output logic                                  csr_pready
);

   localparam int RowBits      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int ColBits      = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
   // The 5-bit count registers cap the usable shape at 31 by 31.
   localparam int EffMaxRows   = (MAX_ROWS < 31) ? MAX_ROWS : 31;
   localparam int EffMaxCols   = (MAX_COLUMNS < 31) ? MAX_COLUMNS : 31;
   localparam int CountBits    = $clog2(EffMaxRows * EffMaxCols + 1);
   localparam logic [6:0] RowLimit = 7'(EffMaxRows);
   localparam logic [6:0] ColLimit = 7'(EffMaxCols);

   logic [smr_pkg::CfgWidth-1:0] row_count_ff, row_count_in;
   logic [smr_pkg::CfgWidth-1:0] column_count_ff, column_count_in;
   logic                         cfg_we;
   logic                         cfg_idx;

   logic [6:0]         rows_eff, cols_eff;
   logic [RowBits-1:0] rows_m1;
   logic [ColBits-1:0] cols_m1;

   smr_pkg::cmd_type    cmd;
   smr_pkg::status_type status;

   // Register write completes in the access phase; pready is tied high.
   assign csr_pready = 1'b1;
   assign cfg_we     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg_idx    = csr_paddr[2];

   always_comb begin
      row_count_in    = row_count_ff;
      column_count_in = column_count_ff;
      if (cfg_we) begin
         unique case (cfg_idx)
            smr_pkg::REG_ROW_COUNT: begin
               row_count_in = csr_pwdata[smr_pkg::CfgWidth-1:0];
            end
            smr_pkg::REG_COLUMN_COUNT: begin
               column_count_in = csr_pwdata[smr_pkg::CfgWidth-1:0];
            end
            default: begin
               row_count_in = row_count_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff    <= smr_pkg::CfgWidth'(4);
         column_count_ff <= smr_pkg::CfgWidth'(4);
      end else begin
         row_count_ff    <= row_count_in;
         column_count_ff <= column_count_in;
      end
   end

   always_comb begin
      unique case (cfg_idx)
         smr_pkg::REG_ROW_COUNT: begin
            csr_prdata = 32'(row_count_ff);
         end
         smr_pkg::REG_COLUMN_COUNT: begin
            csr_prdata = 32'(column_count_ff);
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   // A count of zero acts as one; a count above the supported size is
   // clamped to that size.
   always_comb begin
      if (row_count_ff == '0) begin
         rows_eff = 7'd1;
      end else if ({2'b00, row_count_ff} > RowLimit) begin
         rows_eff = RowLimit;
      end else begin
         rows_eff = {2'b00, row_count_ff};
      end
      if (column_count_ff == '0) begin
         cols_eff = 7'd1;
      end else if ({2'b00, column_count_ff} > ColLimit) begin
         cols_eff = ColLimit;
      end else begin
         cols_eff = {2'b00, column_count_ff};
      end
   end

   assign rows_m1 = RowBits'(rows_eff - 7'd1);
   assign cols_m1 = ColBits'(cols_eff - 7'd1);

   // Every input beat is taken as it arrives.
   assign busy = 1'b0;

   smr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start && !busy),
      .operation (req_operation),
      .cfg_we    (cfg_we),
      .status    (status),
      .cmd       (cmd)
   );

   smr_dpath #(
      .MAX_ROWS    (MAX_ROWS),
      .MAX_COLUMNS (MAX_COLUMNS),
      .RowBits     (RowBits),
      .ColBits     (ColBits),
      .CountBits   (CountBits)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .rows_m1       (rows_m1),
      .cols_m1       (cols_m1),
      .element       (req_element),
      .status        (status),
      .rsp_valid     (rsp_valid),
      .rsp_value     (rsp_value),
      .rsp_last      (rsp_last),
      .rsp_empty_res (rsp_empty_res)
   );

endmodule

>>> tb/sv/spiral_matrix_reader_core_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the spiral matrix reader.
// The driver presents beats from a queue that the stimulus process fills
// one shape at a time. The bench keeps its own model of the block: every
// accepted beat updates that model, and each request beat adds one
// expected result. The monitor compares every result beat, field by
// field, with the oldest expected result.
module spiral_matrix_reader_core_tb;

   localparam int MaxRows      = 16;
   localparam int MaxColumns   = 16;
   localparam int StoreDepth   = MaxRows * MaxColumns;
   localparam int SettleCycles = 4;
   localparam int QuietLimit   = 2000;
   localparam int PrintLimit   = 40;

   // One beat of the input channel.
   typedef struct packed {
      logic                          op;
      logic [smr_pkg::DataWidth-1:0] element;
   } smr_beat_type;

   // One beat of the result channel, as the model predicts it.
   typedef struct packed {
      logic [smr_pkg::DataWidth-1:0] value;
      logic                          last;
      logic                          empty;
   } spiral_result_type;

   // Every input of the block starts at a known value.
   logic                                 clock         = 1'b0;
   logic                                 reset         = 1'b1;
   logic                                 start         = 1'b0;
   logic                                 busy;
   logic                                 req_operation = 1'b0;
   logic signed [smr_pkg::DataWidth-1:0] req_element   = '0;
   logic                                 rsp_valid;
   logic signed [smr_pkg::DataWidth-1:0] rsp_value;
   logic                                 rsp_last;
   logic                                 rsp_empty_res;
   logic                                 csr_psel      = 1'b0;
   logic                                 csr_penable   = 1'b0;
   logic                                 csr_pwrite    = 1'b0;
   logic [smr_pkg::CsrAddrBits-1:0]      csr_paddr     = '0;
   logic [31:0]                          csr_pwdata    = '0;
   logic [31:0]                          csr_prdata;
   logic                                 csr_pready;

   spiral_matrix_reader_core #(
      .MAX_ROWS   (MaxRows),
      .MAX_COLUMNS(MaxColumns)
   ) dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_operation(req_operation),
      .req_element  (req_element),
      .rsp_valid    (rsp_valid),
      .rsp_value    (rsp_value),
      .rsp_last     (rsp_last),
      .rsp_empty_res(rsp_empty_res),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Beats waiting to be driven, and results that requests have earned.
   smr_beat_type      pending_beats[$];
   spiral_result_type results_due[$];

   int mismatch_count = 0;
   int beats_taken    = 0;
   int results_seen   = 0;
   int last_seen      = 0;
   int empty_seen     = 0;
   int shapes_used    = 1;
   int quiet_cycles   = 0;
   int sender_idle_pct = 0;

   // Load pointer as the stimulus generator expects it to stand once the
   // queued beats have run; lets it plan loads that complete the matrix.
   int load_fill = 0;

   smr_beat_type      taken_beat;
   spiral_result_type result_now;

   // ------------------------------------------------------------------
   // Model of the block.
   // ------------------------------------------------------------------
   logic [smr_pkg::CfgWidth-1:0]  row_count_reg;
   logic [smr_pkg::CfgWidth-1:0]  column_count_reg;
   logic [smr_pkg::DataWidth-1:0] element_store [StoreDepth];
   logic [8:0]                    loaded_count_q;
   logic [8:0]                    emitted_count_q;
   int                            top_limit;
   int                            bottom_limit;
   int                            left_limit;
   int                            right_limit;
   logic [1:0]                    walk_dir;
   int                            walk_row;
   int                            walk_col;

   // A count of zero acts as one, and one above the maximum acts as the maximum.
   function automatic int rows_in_use();
      if (row_count_reg == 0) return 1;
      if (row_count_reg > MaxRows) return MaxRows;
      return int'(row_count_reg);
   endfunction

   function automatic int columns_in_use();
      if (column_count_reg == 0) return 1;
      if (column_count_reg > MaxColumns) return MaxColumns;
      return int'(column_count_reg);
   endfunction

   function automatic int shape_total();
      return rows_in_use() * columns_in_use();
   endfunction

   task automatic spiral_rewind();
      emitted_count_q = '0;
      top_limit       = 0;
      left_limit      = 0;
      bottom_limit    = rows_in_use() - 1;
      right_limit     = columns_in_use() - 1;
      walk_dir        = smr_pkg::DIR_RIGHT;
      walk_row        = 0;
      walk_col        = 0;
   endtask

   // Moves to the next spiral position; at the end of a side the bound just
   // finished closes in and the walk turns clockwise.
   task automatic spiral_advance();
      case (walk_dir)
         smr_pkg::DIR_RIGHT: begin
            if (walk_col < right_limit) begin
               walk_col++;
            end else begin
               top_limit++;
               walk_dir = smr_pkg::DIR_DOWN;
               walk_row = top_limit;
               walk_col = right_limit;
            end
         end
         smr_pkg::DIR_DOWN: begin
            if (walk_row < bottom_limit) begin
               walk_row++;
            end else begin
               right_limit--;
               walk_dir = smr_pkg::DIR_LEFT;
               walk_col = right_limit;
               walk_row = bottom_limit;
            end
         end
         smr_pkg::DIR_LEFT: begin
            if (walk_col > left_limit) begin
               walk_col--;
            end else begin
               bottom_limit--;
               walk_dir = smr_pkg::DIR_UP;
               walk_row = bottom_limit;
               walk_col = left_limit;
            end
         end
         default: begin
            if (walk_row > top_limit) begin
               walk_row--;
            end else begin
               left_limit++;
               walk_dir = smr_pkg::DIR_RIGHT;
               walk_col = left_limit;
               walk_row = top_limit;
            end
         end
      endcase
   endtask

   task automatic model_reset();
      row_count_reg    = 5'd4;
      column_count_reg = 5'd4;
      loaded_count_q   = '0;
      spiral_rewind();
   endtask

   // A register write restarts both loading and the spiral.
   task automatic apply_register(logic index, logic [31:0] data);
      if (index == smr_pkg::REG_ROW_COUNT) begin
         row_count_reg = data[smr_pkg::CfgWidth-1:0];
      end else begin
         column_count_reg = data[smr_pkg::CfgWidth-1:0];
      end
      loaded_count_q = '0;
      spiral_rewind();
   endtask

   task automatic predict_spiral_beat(smr_beat_type beat);
      int                total;
      int                row;
      int                col;
      spiral_result_type res;
      total = shape_total();
      if (beat.op == smr_pkg::OP_LOAD) begin
         // A load into a full matrix starts a new one at the first entry.
         if (loaded_count_q >= total) loaded_count_q = '0;
         row = int'(loaded_count_q) / columns_in_use();
         col = int'(loaded_count_q) % columns_in_use();
         element_store[row * MaxColumns + col] = beat.element;
         loaded_count_q = loaded_count_q + 1'b1;
         spiral_rewind();
      end else if (loaded_count_q < total || emitted_count_q >= total) begin
         // Not fully loaded yet, or the spiral is already used up.
         res.value = '0;
         res.last  = 1'b0;
         res.empty = 1'b1;
         results_due.insert(results_due.size(), res);
      end else begin
         res.value = element_store[walk_row * MaxColumns + walk_col];
         emitted_count_q = emitted_count_q + 1'b1;
         res.last  = (emitted_count_q == total);
         res.empty = 1'b0;
         results_due.insert(results_due.size(), res);
         spiral_advance();
      end
   endtask

   // ------------------------------------------------------------------
   // Driver: one beat is taken at each edge where start is high and busy
   // is low. The next beat, or an idle cycle, is chosen at the same edge.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            taken_beat = pending_beats.pop_front();
            predict_spiral_beat(taken_beat);
            beats_taken++;
         end
         if (pending_beats.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            start         <= 1'b1;
            req_operation <= pending_beats[0].op;
            req_element   <= pending_beats[0].element;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor: a result beat lasts exactly one cycle and is taken at the
   // edge that ends it; the bench cannot hold it off.
   // ------------------------------------------------------------------
   task automatic report_mismatch(string what);
      mismatch_count++;
      if (mismatch_count <= PrintLimit) $display("ERROR at %0t: %s", $realtime, what);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         results_seen++;
         if (results_due.size() == 0) begin
            report_mismatch($sformatf("result beat with none outstanding, value %h",
                                      rsp_value));
         end else begin
            result_now = results_due.pop_front();
            if (rsp_value !== result_now.value)
               report_mismatch($sformatf("result %0d value %h, predicted %h",
                                         results_seen, rsp_value, result_now.value));
            if (rsp_last !== result_now.last)
               report_mismatch($sformatf("result %0d last %b, predicted %b",
                                         results_seen, rsp_last, result_now.last));
            if (rsp_empty_res !== result_now.empty)
               report_mismatch($sformatf("result %0d empty %b, predicted %b",
                                         results_seen, rsp_empty_res, result_now.empty));
            if (result_now.last) last_seen++;
            if (result_now.empty) empty_seen++;
         end
      end
   end

   // Watchdog: any taken beat, result beat or register access counts as progress.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid === 1'b1 || (csr_psel && csr_penable)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QuietLimit) begin
            $display("Timeout: no beat moved for %0d cycles", QuietLimit);
            $display("Mismatches found");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus.
   // ------------------------------------------------------------------
   function automatic logic [smr_pkg::DataWidth-1:0] random_element();
      if ($urandom_range(7) == 0) begin
         case ($urandom_range(3))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
         endcase
      end
      return $urandom();
   endfunction

   task automatic queue_load(logic [smr_pkg::DataWidth-1:0] value);
      smr_beat_type beat;
      if (load_fill >= shape_total()) load_fill = 0;
      load_fill++;
      beat.op      = smr_pkg::OP_LOAD;
      beat.element = value;
      pending_beats.insert(pending_beats.size(), beat);
   endtask

   // The element field of a request is ignored, so it carries noise.
   task automatic queue_request();
      smr_beat_type beat;
      beat.op      = smr_pkg::OP_REQUEST;
      beat.element = $urandom();
      pending_beats.insert(pending_beats.size(), beat);
   endtask

   // Number of loads that leave the matrix full from the planned load pointer.
   function automatic int loads_to_fill();
      if (load_fill == 0 || load_fill >= shape_total()) return shape_total();
      return shape_total() - load_fill;
   endfunction

   // Most sequences fill the matrix and walk the whole spiral; the rest
   // stop short, restart the spiral mid-walk, or are plain noise.
   task automatic queue_random_sequence(bit clean);
      int total;
      int kind;
      total = shape_total();
      kind  = clean ? 0 : int'($urandom_range(9));
      if (kind <= 5) begin
         if (!clean && $urandom_range(3) == 0) queue_request();
         repeat (loads_to_fill()) queue_load(random_element());
         repeat (total + (clean ? 1 : int'($urandom_range(2)))) queue_request();
      end else if (kind == 6) begin
         repeat ($urandom_range(total, 1)) queue_load(random_element());
         repeat ($urandom_range(3, 1)) queue_request();
      end else if (kind == 7) begin
         repeat (loads_to_fill()) queue_load(random_element());
         repeat ($urandom_range(total, 1)) queue_request();
         queue_load(random_element());
         repeat ($urandom_range(3, 1)) queue_request();
      end else begin
         repeat ($urandom_range(12, 6)) begin
            if ($urandom_range(1) == 1) queue_request();
            else queue_load(random_element());
         end
      end
   endtask

   // Waits until every queued beat is taken and every
   // result has come, then lets the block settle; loads leave no result.
   task automatic wait_for_idle();
      while (pending_beats.size() != 0 || results_due.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_shape_register(logic index, logic [31:0] data);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      apply_register(index, data);
   endtask

   task automatic set_shape(int rows, int columns);
      write_shape_register(smr_pkg::REG_ROW_COUNT, rows);
      write_shape_register(smr_pkg::REG_COLUMN_COUNT, columns);
      shapes_used++;
   endtask

   task automatic run_phase(int budget, int idle_pct, bit clean);
      sender_idle_pct = idle_pct;
      load_fill       = int'(loaded_count_q);
      while (pending_beats.size() < budget) queue_random_sequence(clean);
      wait_for_idle();
   endtask

   initial begin
      model_reset();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The shape left by reset, four by four.
      run_phase(30, 32, 1'b0);

      // Directed beats on a two by three matrix. A request before any load
      // must come back empty, the loads carry the extreme values, and a load
      // into the full matrix starts a new one so that the following request
      // is empty again until the matrix is refilled.
      set_shape(2, 3);
      sender_idle_pct = 32;
      load_fill       = 0;
      queue_request();
      queue_load(32'h8000_0000);
      queue_load(32'h7FFF_FFFF);
      queue_load(32'h0000_0000);
      queue_load(32'hFFFF_FFFF);
      queue_load(32'h5555_5555);
      queue_load(32'hAAAA_AAAA);
      repeat (2) queue_request();
      queue_load(32'h1234_5678);
      queue_request();
      repeat (5) queue_load(random_element());
      // Six elements of the spiral and one request past its end.
      repeat (7) queue_request();
      wait_for_idle();

      // Single element, then out-of-range counts: zero acts as one and
      // anything above sixteen acts as sixteen.
      set_shape(1, 1);
      run_phase(20, 32, 1'b0);
      set_shape(0, 16);
      run_phase(20, 32, 1'b0);

      set_shape(16, 0);
      run_phase(20, 71, 1'b0);
      set_shape(3, 5);
      run_phase(20, 71, 1'b0);
      set_shape($urandom_range(6, 1), $urandom_range(6, 1));
      run_phase(20, 71, 1'b0);

      // The largest matrix, set through counts beyond the maximum; one
      // clean pass reaches the far corners and the innermost turn.
      set_shape(31, 17);
      run_phase(1, 0, 1'b1);
      repeat (2) begin
         set_shape($urandom_range(6, 1), $urandom_range(6, 1));
         run_phase(20, 0, 1'b0);
      end

      wait_for_idle();
      $display("Covered %0d input beats and %0d result beats (%0d final, %0d empty).",
               beats_taken, results_seen, last_seen, empty_seen);
      $display("Ran %0d shapes, one element up to sixteen by sixteen, with clamped counts.",
               shapes_used);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
